// File: sv/pafa_pkg.sv
// Shared types and constants for the paged arena first-fit allocator.
// No dependencies; the interfaces, core, config registers and adder import this package.
package pafa_pkg;

    localparam int HEAPS_DEF     = 8;
    localparam int MAX_PAGES_DEF = 16;

    localparam int OP_W    = 2;
    localparam int HEAP_W  = 3;
    localparam int SIZE_W  = 32;
    localparam int PAGE_W  = 4;
    localparam int OFS_W   = 34;
    localparam int GRAN_W  = 33;
    localparam int PSIZE_W = 34;
    localparam int TOTAL_W = 48;
    localparam int ALIGN_W = 5;
    localparam int BMIN_W  = 34;
    localparam int MASK_W  = 8;
    localparam int ADD_W   = 48;
    localparam int CFG_AW  = 5;
    localparam int CFG_DW  = 64;

    localparam logic [OP_W-1:0] OP_ALLOC     = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR     = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR_ALL = 2'd2;

    localparam logic [1:0] REG_ALIGN  = 2'd0;
    localparam logic [1:0] REG_BMIN   = 2'd1;
    localparam logic [1:0] REG_DLMASK = 2'd2;

    localparam logic [ALIGN_W-1:0] ALIGN_RST  = 5'd8;
    localparam logic [BMIN_W-1:0]  BMIN_RST   = 34'd2560;
    localparam logic [MASK_W-1:0]  DLMASK_RST = 8'hFF;

    typedef struct packed {
        logic [ALIGN_W-1:0] align_log2;
        logic [BMIN_W-1:0]  block_min;
        logic [MASK_W-1:0]  dl_mask;
    } t_cfg;

    typedef struct packed {
        logic               status;
        logic [PAGE_W-1:0]  page;
        logic [OFS_W-1:0]   offset;
        logic [GRAN_W-1:0]  granted_size;
        logic               new_page;
        logic [PSIZE_W-1:0] page_size;
        logic [TOTAL_W-1:0] heap_bytes;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_NEWPG,
        ST_COMMIT,
        ST_TOTAL,
        ST_CLEAR,
        ST_RESULT
    } t_state;

endpackage

// File: sv/pafa_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on pafa_pkg for field widths.
interface pafa_req_if;
    import pafa_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [HEAP_W-1:0] heap;
    logic [SIZE_W-1:0] size;
    modport source (output valid, op, heap, size, input ready);
    modport sink   (input valid, op, heap, size, output ready);
endinterface

interface pafa_rsp_if;
    import pafa_pkg::*;
    logic               valid;
    logic               ready;
    logic               status;
    logic [PAGE_W-1:0]  page;
    logic [OFS_W-1:0]   offset;
    logic [GRAN_W-1:0]  granted_size;
    logic               new_page;
    logic [PSIZE_W-1:0] page_size;
    logic [TOTAL_W-1:0] heap_bytes;
    modport source (output valid, status, page, offset, granted_size, new_page,
                    page_size, heap_bytes, input ready);
    modport sink   (input valid, status, page, offset, granted_size, new_page,
                    page_size, heap_bytes, output ready);
endinterface

// File: sv/paged_arena_first_fit_allocator_core.sv
// Paged first-fit arena allocator, one arena per heap, one request at a time.
// Allocate: scan the heap's open pages (one page entry read per cycle); if none fits, open a
// page, then head bump, total, result. No fit with a full page table returns a failure.
// Clear one heap zeroes the heads of its 2**clog2(MAX_PAGES) page slots; clear all does so for every heap.
// Next request is taken the cycle after its result is registered; op 3 goes straight to the result.
// Reset: page counts and byte totals zero, config at defaults; page table untouched.
module paged_arena_first_fit_allocator_core #(
    parameter int HEAPS     = pafa_pkg::HEAPS_DEF,
    parameter int MAX_PAGES = pafa_pkg::MAX_PAGES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    pafa_req_if.sink                     i_req,
    pafa_rsp_if.source                   o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pafa_pkg::CFG_AW-1:0]  paddr,
    input  logic [pafa_pkg::CFG_DW-1:0]  pwdata,
    output logic [pafa_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready
);
    import pafa_pkg::*;

    localparam int HW = (HEAPS > 1) ? $clog2(HEAPS) : 1;
    localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CW = $clog2(MAX_PAGES + 1);
    localparam int AW = HW + PW;
    localparam logic [AW-1:0] LAST_ADDR = AW'(HEAPS * (2**PW) - 1);

    t_cfg cfg;

    pafa_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // control state
    t_state             r_state, n_state;
    logic [CW-1:0]      r_pages_open [HEAPS];
    logic [CW-1:0]      n_pages_open [HEAPS];
    logic [TOTAL_W-1:0] r_total [HEAPS];
    logic [TOTAL_W-1:0] n_total [HEAPS];
    logic               r_out_valid, n_out_valid;
    logic               r_dv, n_dv;

    // per-request payload
    logic [OP_W-1:0]    r_op, n_op;
    logic [HEAP_W-1:0]  r_heap, n_heap;
    logic [GRAN_W-1:0]  r_gran, n_gran;
    logic               r_whole, n_whole;
    logic               r_present, n_present;
    logic               r_fail, n_fail;
    logic               r_ok, n_ok;
    logic               r_newp, n_newp;
    logic [CW-1:0]      r_scan, n_scan;
    logic [CW-1:0]      r_dpage, n_dpage;
    logic [PW-1:0]      r_hit, n_hit;
    logic [OFS_W-1:0]   r_offset, n_offset;
    logic [PSIZE_W-1:0] r_psize, n_psize;
    logic [AW-1:0]      r_sweep, n_sweep;
    t_rsp               r_out, n_out;

    // memories and shared unit
    logic               head_we, cap_we;
    logic [AW-1:0]      head_waddr, cap_waddr, rd_addr;
    logic [OFS_W-1:0]   head_wdata, rd_head;
    logic [PSIZE_W-1:0] cap_wdata, rd_cap;
    logic [ADD_W-1:0]   add_a, add_b, add_c;
    logic [ADD_W:0]     add_sum;
    logic               add_le;

    logic [HW-1:0]      hidx, in_hidx;
    logic [CW-1:0]      open_h;
    logic [OFS_W-1:0]   amask, rounded;
    logic [PSIZE_W-1:0] psize_raw;
    logic               fit, in_present;

    pafa_page_ram #(.W(OFS_W), .AW(AW)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_head)
    );

    pafa_page_ram #(.W(PSIZE_W), .AW(AW)) u_cap_ram (
        .i_clk   (i_clk),
        .i_we    (cap_we),
        .i_waddr (cap_waddr),
        .i_wdata (cap_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_cap)
    );

    pafa_add_unit u_add (
        .i_a   (add_a),
        .i_b   (add_b),
        .i_c   (add_c),
        .o_sum (add_sum),
        .o_le  (add_le)
    );

    assign hidx       = HW'(r_heap);
    assign in_hidx    = HW'(i_req.heap);
    assign in_present = 32'(i_req.heap) < HEAPS;
    assign open_h     = r_pages_open[hidx];
    assign amask      = (OFS_W'(1) << cfg.align_log2) - OFS_W'(1);
    assign rounded    = (OFS_W'(i_req.size) + amask) & ~amask;
    assign psize_raw  = r_whole ? PSIZE_W'(r_gran) : {r_gran, 1'b0};
    assign fit        = (!r_whole || rd_head == '0) && add_le;
    assign rd_addr    = {hidx, r_scan[PW-1:0]};

    assign i_req.ready        = (r_state == ST_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.page         = r_out.page;
    assign o_rsp.offset       = r_out.offset;
    assign o_rsp.granted_size = r_out.granted_size;
    assign o_rsp.new_page     = r_out.new_page;
    assign o_rsp.page_size    = r_out.page_size;
    assign o_rsp.heap_bytes   = r_out.heap_bytes;

    always_comb begin
        n_state      = r_state;
        n_pages_open = r_pages_open;
        n_total      = r_total;
        n_out_valid  = r_out_valid;
        n_dv         = 1'b0;
        n_op         = r_op;
        n_heap       = r_heap;
        n_gran       = r_gran;
        n_whole      = r_whole;
        n_present    = r_present;
        n_fail       = r_fail;
        n_ok         = r_ok;
        n_newp       = r_newp;
        n_scan       = r_scan;
        n_dpage      = r_dpage;
        n_hit        = r_hit;
        n_offset     = r_offset;
        n_psize      = r_psize;
        n_sweep      = r_sweep;
        n_out        = r_out;
        head_we      = 1'b0;
        head_waddr   = {hidx, r_hit};
        head_wdata   = add_sum[OFS_W-1:0];
        cap_we       = 1'b0;
        cap_waddr    = {hidx, open_h[PW-1:0]};
        cap_wdata    = add_le ? psize_raw : cfg.block_min;
        add_a        = '0;
        add_b        = '0;
        add_c        = '0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_op      = i_req.op;
                    n_heap    = i_req.heap;
                    n_gran    = rounded[GRAN_W-1:0];
                    n_whole   = !cfg.dl_mask[i_req.heap];
                    n_present = in_present;
                    n_fail    = 1'b0;
                    n_ok      = 1'b0;
                    n_scan    = '0;
                    unique case (i_req.op)
                        OP_ALLOC: begin
                            if (!in_present) begin
                                n_fail  = 1'b1;
                                n_state = ST_RESULT;
                            end else if (r_pages_open[in_hidx] == '0) begin
                                n_state = ST_NEWPG;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            n_sweep = {in_hidx, PW'(0)};
                            n_state = in_present ? ST_CLEAR : ST_RESULT;
                        end
                        OP_CLEAR_ALL: begin
                            n_sweep = '0;
                            n_state = ST_CLEAR;
                        end
                        default: n_state = ST_RESULT;
                    endcase
                end
            end
            ST_SCAN: begin
                // read of page r_scan is issued now; data for r_dpage is back
                add_a = ADD_W'(rd_head);
                add_b = ADD_W'(r_gran);
                add_c = ADD_W'(rd_cap);
                if (r_scan < open_h) begin
                    n_scan  = r_scan + CW'(1);
                    n_dv    = 1'b1;
                    n_dpage = r_scan;
                end
                if (r_dv) begin
                    if (fit) begin
                        n_hit    = r_dpage[PW-1:0];
                        n_offset = rd_head;
                        n_newp   = 1'b0;
                        n_psize  = '0;
                        n_state  = ST_COMMIT;
                    end else if (r_dpage == open_h - CW'(1)) begin
                        if (open_h == CW'(MAX_PAGES)) begin
                            n_fail  = 1'b1;
                            n_state = ST_RESULT;
                        end else begin
                            n_state = ST_NEWPG;
                        end
                    end
                end
            end
            ST_NEWPG: begin
                // page size floored at block minimum via compare
                add_a  = ADD_W'(cfg.block_min);
                add_c  = ADD_W'(psize_raw);
                cap_we = 1'b1;
                n_psize  = cap_wdata;
                n_hit    = open_h[PW-1:0];
                n_offset = '0;
                n_newp   = 1'b1;
                n_pages_open[hidx] = open_h + CW'(1);
                n_state  = ST_COMMIT;
            end
            ST_COMMIT: begin
                add_a   = ADD_W'(r_offset);
                add_b   = ADD_W'(r_gran);
                head_we = 1'b1;
                n_state = ST_TOTAL;
            end
            ST_TOTAL: begin
                add_a = r_total[hidx];
                add_b = ADD_W'(r_gran);
                n_total[hidx] = add_sum[ADD_W] ? '1 : add_sum[TOTAL_W-1:0];
                n_ok    = 1'b1;
                n_state = ST_RESULT;
            end
            ST_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = r_sweep;
                head_wdata = '0;
                n_sweep    = r_sweep + AW'(1);
                if (r_op == OP_CLEAR_ALL) begin
                    if (r_sweep == LAST_ADDR) begin
                        n_state = ST_RESULT;
                    end
                end else if (&r_sweep[PW-1:0]) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid        = 1'b1;
                    n_out.status       = r_fail;
                    n_out.page         = r_ok ? PAGE_W'(r_hit) : '0;
                    n_out.offset       = r_ok ? r_offset : '0;
                    n_out.granted_size = r_ok ? r_gran : '0;
                    n_out.new_page     = r_ok && r_newp;
                    n_out.page_size    = r_ok ? r_psize : '0;
                    n_out.heap_bytes   = r_present ? r_total[hidx] : '0;
                    n_state            = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_dv        <= 1'b0;
            for (int h = 0; h < HEAPS; h++) begin
                r_pages_open[h] <= '0;
                r_total[h]      <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_dv         <= n_dv;
            r_pages_open <= n_pages_open;
            r_total      <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_heap    <= n_heap;
        r_gran    <= n_gran;
        r_whole   <= n_whole;
        r_present <= n_present;
        r_fail    <= n_fail;
        r_ok      <= n_ok;
        r_newp    <= n_newp;
        r_scan    <= n_scan;
        r_dpage   <= n_dpage;
        r_hit     <= n_hit;
        r_offset  <= n_offset;
        r_psize   <= n_psize;
        r_sweep   <= n_sweep;
        r_out     <= n_out;
    end

endmodule

// File: sv/pafa_cfg_regs.sv
// APB-style configuration registers: alignment, minimum page size, heap mask.
// Depends on pafa_pkg.
module pafa_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pafa_pkg::CFG_AW-1:0]  paddr,
    input  logic [pafa_pkg::CFG_DW-1:0]  pwdata,
    output logic [pafa_pkg::CFG_DW-1:0]  prdata,
    output logic                         pready,
    output pafa_pkg::t_cfg               o_cfg
);
    import pafa_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:3];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.align_log2 <= ALIGN_RST;
            r_cfg.block_min  <= BMIN_RST;
            r_cfg.dl_mask    <= DLMASK_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ALIGN:  r_cfg.align_log2 <= pwdata[ALIGN_W-1:0];
                REG_BMIN:   r_cfg.block_min  <= pwdata[BMIN_W-1:0];
                REG_DLMASK: r_cfg.dl_mask    <= pwdata[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ALIGN:  prdata = CFG_DW'(r_cfg.align_log2);
            REG_BMIN:   prdata = CFG_DW'(r_cfg.block_min);
            REG_DLMASK: prdata = CFG_DW'(r_cfg.dl_mask);
            default:    prdata = '0;
        endcase
    end

endmodule

// File: sv/pafa_page_ram.sv
// Single-write, single-read page table memory with registered read data.
// Depends on nothing but the widths passed in.
module pafa_page_ram #(
    parameter int W  = 34,
    parameter int AW = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [2**AW];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/pafa_add_unit.sv
// Shared 48-bit adder with compare: sum = a + b, le = (a + b) <= c.
// Used for the fit test, page size floor, head bump and total update.
module pafa_add_unit (
    input  logic [pafa_pkg::ADD_W-1:0] i_a,
    input  logic [pafa_pkg::ADD_W-1:0] i_b,
    input  logic [pafa_pkg::ADD_W-1:0] i_c,
    output logic [pafa_pkg::ADD_W:0]   o_sum,
    output logic                       o_le
);
    import pafa_pkg::*;

    assign o_sum = {1'b0, i_a} + {1'b0, i_b};
    assign o_le  = o_sum <= {1'b0, i_c};

endmodule
